### hdl/ncaa_pkg.sv
// Shared constants, types and codes of the nearest centroid assignment block.
package ncaa_pkg;

	localparam int CLUSTER_SLOTS = 16;
	localparam int CL_BITS = $clog2(CLUSTER_SLOTS);
	localparam int DIMS = 4;
	localparam int DIM_BITS = $clog2(DIMS);
	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS = 16;
	localparam int TRI = (DIMS * (DIMS + 1)) / 2;
	localparam int SUM_BITS = 32;
	localparam int SCAT_BITS = 48;
	localparam int DIST_BITS = 52;
	localparam int WEIGHT_BITS = 16;
	localparam int SQ_BITS = 2 * SAMPLE_BITS;
	localparam int TERM_BITS = SQ_BITS + WEIGHT_BITS;
	localparam int PAIR_BITS = TERM_BITS + 1;
	localparam int ACC_BITS = TERM_BITS + 2;
	localparam int NC_BITS = 5;
	localparam int ND_BITS = 3;
	localparam int SEL_BITS = 4;
	localparam int Q_DEPTH = 2;
	localparam int Q_BITS = 1;
	localparam int PADDR_BITS = 5;

	localparam logic [2:0] REG_ACTIVE_CLUSTERS = 3'd0;
	localparam logic [2:0] REG_ACTIVE_DIMS = 3'd1;
	localparam logic [2:0] REG_WEIGHT_DIM0 = 3'd2;
	localparam logic [2:0] REG_WEIGHT_DIM1 = 3'd3;
	localparam logic [2:0] REG_WEIGHT_DIM2 = 3'd4;
	localparam logic [2:0] REG_WEIGHT_DIM3 = 3'd5;

	typedef enum logic [1:0] {
		CMD_OBSERVE = 2'd0,
		CMD_LOAD = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_SAT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_ACC_RD,
		S_ACC_WR,
		S_RD_RD,
		S_RD_WR
	} state_t;

	typedef struct packed {
		logic [NC_BITS-1:0] clusters;
		logic [ND_BITS-1:0] dims;
		logic [DIMS-1:0][WEIGHT_BITS-1:0] weight;
	} cfg_t;

	typedef struct packed {
		cmd_t cmd;
		logic [DIMS-1:0][SAMPLE_BITS-1:0] elem;
		logic [CL_BITS-1:0] tgt;
		logic [SEL_BITS-1:0] sel;
		logic bad;
	} item_t;

	typedef struct packed {
		logic [DIMS-1:0][SUM_BITS-1:0] sum;
		logic [TRI-1:0][SCAT_BITS-1:0] scat;
	} stat_row_t;

endpackage

### hdl/ncaa_regs.sv
// APB configuration registers with effective cluster and dimension counts.
module ncaa_regs import ncaa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_BITS-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	logic [NC_BITS-1:0] clusters_q;
	logic [ND_BITS-1:0] dims_q;
	logic [DIMS-1:0][WEIGHT_BITS-1:0] weight_q;
	logic [2:0] idx;
	logic wr;

	assign pready = 1'b1;
	assign idx = paddr[4:2];
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clusters_q <= NC_BITS'(1);
			dims_q <= ND_BITS'(4);
			for (int d = 0; d < DIMS; d++) begin
				weight_q[d] <= WEIGHT_BITS'(256);
			end
		end else if (wr) begin
			case (idx)
				REG_ACTIVE_CLUSTERS: clusters_q <= pwdata[NC_BITS-1:0];
				REG_ACTIVE_DIMS: dims_q <= pwdata[ND_BITS-1:0];
				REG_WEIGHT_DIM0: weight_q[0] <= pwdata[WEIGHT_BITS-1:0];
				REG_WEIGHT_DIM1: weight_q[1] <= pwdata[WEIGHT_BITS-1:0];
				REG_WEIGHT_DIM2: weight_q[2] <= pwdata[WEIGHT_BITS-1:0];
				REG_WEIGHT_DIM3: weight_q[3] <= pwdata[WEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ACTIVE_CLUSTERS: prdata = 32'(clusters_q);
			REG_ACTIVE_DIMS: prdata = 32'(dims_q);
			REG_WEIGHT_DIM0: prdata = 32'(weight_q[0]);
			REG_WEIGHT_DIM1: prdata = 32'(weight_q[1]);
			REG_WEIGHT_DIM2: prdata = 32'(weight_q[2]);
			REG_WEIGHT_DIM3: prdata = 32'(weight_q[3]);
			default: prdata = 32'd0;
		endcase
	end

	always_comb begin
		cfg.weight = weight_q;
		if (clusters_q == '0) begin
			cfg.clusters = NC_BITS'(1);
		end else if (clusters_q > NC_BITS'(CLUSTER_SLOTS)) begin
			cfg.clusters = NC_BITS'(CLUSTER_SLOTS);
		end else begin
			cfg.clusters = clusters_q;
		end
		if (dims_q == '0) begin
			cfg.dims = ND_BITS'(1);
		end else if (dims_q > ND_BITS'(DIMS)) begin
			cfg.dims = ND_BITS'(DIMS);
		end else begin
			cfg.dims = dims_q;
		end
	end

endmodule

### hdl/ncaa_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
module ncaa_front import ncaa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] command,
	input logic signed [SAMPLE_BITS-1:0] elem0,
	input logic signed [SAMPLE_BITS-1:0] elem1,
	input logic signed [SAMPLE_BITS-1:0] elem2,
	input logic signed [SAMPLE_BITS-1:0] elem3,
	input logic [CL_BITS-1:0] target_cluster,
	input logic [SEL_BITS-1:0] selector_index,
	output logic q_valid,
	output item_t q_item,
	input logic q_pop
);

	item_t item_q [Q_DEPTH];
	item_t item_in;
	logic [Q_BITS-1:0] wr_ptr_q;
	logic [Q_BITS-1:0] rd_ptr_q;
	logic [Q_BITS:0] fill_q;
	logic push;
	logic bad_load;
	logic bad_read;

	assign in_stall = (fill_q == (Q_BITS+1)'(Q_DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (fill_q != '0);
	assign q_item = item_q[rd_ptr_q];

	always_comb begin
		bad_load = (selector_index >= SEL_BITS'(DIMS));
		if (selector_index >= SEL_BITS'(DIMS + 1 + (4 - DIMS))) begin
			bad_read = ((selector_index - SEL_BITS'(5)) >= SEL_BITS'(TRI));
		end else begin
			bad_read = (selector_index != '0) && ((selector_index - SEL_BITS'(1)) >= SEL_BITS'(DIMS));
		end
		item_in.cmd = cmd_t'(command);
		item_in.elem = {elem3, elem2, elem1, elem0};
		item_in.tgt = target_cluster;
		item_in.sel = selector_index;
		case (cmd_t'(command))
			CMD_LOAD: item_in.bad = bad_load;
			CMD_READ: item_in.bad = bad_read;
			default: item_in.bad = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

### hdl/ncaa_back.sv
// Back end: distance search pipeline, statistics store and result register.
module ncaa_back import ncaa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic q_valid,
	input item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input logic out_stall,
	output logic [CL_BITS-1:0] chosen_cluster,
	output logic [DIST_BITS-1:0] min_distance,
	output logic signed [SCAT_BITS-1:0] read_value,
	output logic [1:0] status
);

	state_t state_q;
	state_t state_next;
	item_t cur_q;

	logic [DIMS-1:0][SAMPLE_BITS-1:0] seed_q [CLUSTER_SLOTS];
	logic [COUNT_BITS-1:0] cnt_q [CLUSTER_SLOTS];
	logic [CLUSTER_SLOTS-1:0] row_valid_q;
	stat_row_t stat_mem [CLUSTER_SLOTS];
	stat_row_t stat_rd_q;
	logic stat_rd_valid_q;

	logic [NC_BITS-1:0] issue_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [CL_BITS-1:0] c_s1, c_s2, c_s3, c_s4, c_s5;
	logic [DIMS-1:0][SAMPLE_BITS-1:0] seed_s1;
	logic [DIMS-1:0][SQ_BITS-1:0] sq_s2;
	logic [DIMS-1:0][TERM_BITS-1:0] term_s3;
	logic [PAIR_BITS-1:0] pair_a_s4, pair_b_s4;
	logic [ACC_BITS-1:0] dist_s5;

	logic [CL_BITS-1:0] best_q;
	logic [ACC_BITS-1:0] best_dist_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [TRI-1:0][SCAT_BITS-1:0] prod_q;

	logic out_valid_q;
	logic [CL_BITS-1:0] chosen_q;
	logic [DIST_BITS-1:0] dist_q;
	logic [SCAT_BITS-1:0] rv_q;
	status_t status_q;

	logic out_free;
	logic out_load;
	logic do_issue;
	logic last_s5;
	logic take_s5;
	logic sat;
	logic stat_we;
	logic [CL_BITS-1:0] stat_addr;
	logic [COUNT_BITS-1:0] cnt_rd;
	stat_row_t stat_old;
	stat_row_t stat_new;
	logic [CL_BITS-1:0] res_chosen;
	logic [DIST_BITS-1:0] res_dist;
	logic [SCAT_BITS-1:0] res_rv;
	status_t res_status;
	logic [SEL_BITS-1:0] sel_sum;
	logic [SEL_BITS-1:0] sel_scat;

	assign out_valid = out_valid_q;
	assign chosen_cluster = chosen_q;
	assign min_distance = dist_q;
	assign read_value = rv_q;
	assign status = status_q;
	assign out_free = !out_valid_q || !out_stall;

	assign sat = (best_cnt_q == '1);
	assign last_s5 = ({1'b0, c_s5} == (cfg.clusters - NC_BITS'(1)));
	assign cnt_rd = cnt_q[(state_q == S_SEARCH) ? c_s5 : cur_q.tgt];
	assign take_s5 = (c_s5 == '0) || (dist_s5 < best_dist_q) ||
		((dist_s5 == best_dist_q) && (cnt_rd < best_cnt_q));
	assign stat_old = stat_rd_valid_q ? stat_rd_q : '0;
	assign sel_sum = cur_q.sel - SEL_BITS'(1);
	assign sel_scat = cur_q.sel - SEL_BITS'(DIMS + 1);

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_pop && q_item.cmd == CMD_OBSERVE) begin
					state_next = S_SEARCH;
				end else if (q_pop && q_item.cmd == CMD_READ) begin
					state_next = S_RD_RD;
				end
			end
			S_SEARCH: begin
				if (v_s5 && last_s5) begin
					state_next = S_ACC_RD;
				end
			end
			S_ACC_RD: state_next = S_ACC_WR;
			S_ACC_WR: begin
				if (out_free) begin
					state_next = S_IDLE;
				end
			end
			S_RD_RD: state_next = S_RD_WR;
			S_RD_WR: begin
				if (out_free) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		out_load = 1'b0;
		stat_we = 1'b0;
		do_issue = (state_q == S_SEARCH) && (issue_q < cfg.clusters);
		stat_addr = (state_q == S_ACC_RD || state_q == S_ACC_WR) ? best_q : cur_q.tgt;
		res_chosen = '0;
		res_dist = '0;
		res_rv = '0;
		res_status = STAT_OK;
		case (state_q)
			S_IDLE: begin
				q_pop = q_valid && (q_item.cmd == CMD_OBSERVE || q_item.cmd == CMD_READ ||
					out_free);
				out_load = q_pop && (q_item.cmd == CMD_LOAD || q_item.cmd == CMD_CLEAR);
				if (q_item.cmd == CMD_LOAD && q_item.bad) begin
					res_status = STAT_RANGE;
				end
			end
			S_ACC_WR: begin
				out_load = out_free;
				stat_we = out_free && !sat;
				res_chosen = best_q;
				res_dist = DIST_BITS'(best_dist_q);
				res_status = sat ? STAT_SAT : STAT_OK;
			end
			S_RD_WR: begin
				out_load = out_free;
				if (cur_q.bad) begin
					res_status = STAT_RANGE;
				end else if (cur_q.sel == '0) begin
					res_rv = SCAT_BITS'(cnt_rd);
				end else if (cur_q.sel <= SEL_BITS'(DIMS)) begin
					res_rv = SCAT_BITS'($signed(stat_old.sum[sel_sum[DIM_BITS-1:0]]));
				end else begin
					res_rv = stat_old.scat[sel_scat];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		stat_new = stat_old;
		for (int d = 0; d < DIMS; d++) begin
			if (ND_BITS'(d) < cfg.dims) begin
				stat_new.sum[d] = stat_old.sum[d] +
					SUM_BITS'($signed(cur_q.elem[d]));
			end
		end
		for (int r = 0; r < DIMS; r++) begin
			for (int c = 0; c <= r; c++) begin
				if (ND_BITS'(r) < cfg.dims) begin
					stat_new.scat[(r * (r + 1)) / 2 + c] =
						stat_old.scat[(r * (r + 1)) / 2 + c] +
						prod_q[(r * (r + 1)) / 2 + c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		seed_s1 <= seed_q[issue_q[CL_BITS-1:0]];
		for (int d = 0; d < DIMS; d++) begin
			logic signed [SAMPLE_BITS:0] diff;
			logic [SAMPLE_BITS:0] ad;
			diff = $signed({seed_s1[d][SAMPLE_BITS-1], seed_s1[d]}) -
				$signed({cur_q.elem[d][SAMPLE_BITS-1], cur_q.elem[d]});
			ad = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
			sq_s2[d] <= ad[SAMPLE_BITS-1:0] * ad[SAMPLE_BITS-1:0];
			term_s3[d] <= (ND_BITS'(d) < cfg.dims) ? (TERM_BITS'(sq_s2[d]) *
				TERM_BITS'(cfg.weight[d])) : '0;
		end
		pair_a_s4 <= PAIR_BITS'(term_s3[0]) + PAIR_BITS'(term_s3[1]);
		pair_b_s4 <= PAIR_BITS'(term_s3[2]) + PAIR_BITS'(term_s3[3]);
		dist_s5 <= ACC_BITS'(pair_a_s4) + ACC_BITS'(pair_b_s4);
		c_s1 <= issue_q[CL_BITS-1:0];
		c_s2 <= c_s1;
		c_s3 <= c_s2;
		c_s4 <= c_s3;
		c_s5 <= c_s4;
		if (state_q == S_SEARCH && v_s5 && take_s5) begin
			best_q <= c_s5;
			best_dist_q <= dist_s5;
			best_cnt_q <= cnt_rd;
		end
		for (int r = 0; r < DIMS; r++) begin
			for (int c = 0; c <= r; c++) begin
				prod_q[(r * (r + 1)) / 2 + c] <= SCAT_BITS'($signed(cur_q.elem[r]) *
					$signed(cur_q.elem[c]));
			end
		end
		stat_rd_q <= stat_mem[stat_addr];
		stat_rd_valid_q <= row_valid_q[stat_addr];
		if (stat_we) begin
			stat_mem[best_q] <= stat_new;
		end
		if (out_load) begin
			chosen_q <= res_chosen;
			dist_q <= res_dist;
			rv_q <= res_rv;
			status_q <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issue_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CLUSTER_SLOTS; c++) begin
				seed_q[c] <= '0;
				cnt_q[c] <= '0;
			end
		end else begin
			state_q <= state_next;
			if (q_pop) begin
				issue_q <= '0;
			end else if (do_issue) begin
				issue_q <= issue_q + NC_BITS'(1);
			end
			v_s1 <= do_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (q_pop && q_item.cmd == CMD_LOAD && !q_item.bad) begin
				seed_q[q_item.tgt][q_item.sel[DIM_BITS-1:0]] <= q_item.elem[0];
			end
			if (q_pop && q_item.cmd == CMD_CLEAR) begin
				for (int c = 0; c < CLUSTER_SLOTS; c++) begin
					if (NC_BITS'(c) < cfg.clusters) begin
						cnt_q[c] <= '0;
						row_valid_q[c] <= 1'b0;
					end
				end
			end
			if (stat_we) begin
				cnt_q[best_q] <= best_cnt_q + COUNT_BITS'(1);
				row_valid_q[best_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/nearest_centroid_assign_accumulate.sv
// Top level of the nearest centroid assignment and statistics block.
// An observe word streams the active cluster seeds, one per cycle, through a five-stage
// weighted distance pipeline and then reads and writes the chosen cluster's statistics
// row; a statistic read reads the row and then loads the result, and a seed load or a
// clear loads its result directly. A two-word queue in front lets new words be accepted
// while one is being worked on, and the result register holds a finished word until it
// is taken. Statistics come out of reset and clear as zero without a clearing pass.
module nearest_centroid_assign_accumulate import ncaa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] command,
	input logic signed [SAMPLE_BITS-1:0] elem0,
	input logic signed [SAMPLE_BITS-1:0] elem1,
	input logic signed [SAMPLE_BITS-1:0] elem2,
	input logic signed [SAMPLE_BITS-1:0] elem3,
	input logic [CL_BITS-1:0] target_cluster,
	input logic [SEL_BITS-1:0] selector_index,
	output logic out_valid,
	input logic out_stall,
	output logic [CL_BITS-1:0] chosen_cluster,
	output logic [DIST_BITS-1:0] min_distance,
	output logic signed [SCAT_BITS-1:0] read_value,
	output logic [1:0] status,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_BITS-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	cfg_t cfg;
	logic q_valid;
	item_t q_item;
	logic q_pop;

	ncaa_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	ncaa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.elem0(elem0),
		.elem1(elem1),
		.elem2(elem2),
		.elem3(elem3),
		.target_cluster(target_cluster),
		.selector_index(selector_index),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	ncaa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.chosen_cluster(chosen_cluster),
		.min_distance(min_distance),
		.read_value(read_value),
		.status(status)
	);

endmodule

### test/tb_nearest_centroid_assign_accumulate.sv
// Self-checking testbench of the nearest centroid assignment and statistics block.
module tb_nearest_centroid_assign_accumulate;
	import ncaa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] DMAX = (64'd1 << DIST_BITS) - 1;
	localparam logic [15:0] CMAX = 16'hFFFF;

	typedef struct {
		logic [CL_BITS-1:0] cl;
		logic [DIST_BITS-1:0] mdist;
		logic [SCAT_BITS-1:0] rv;
		logic [1:0] st;
	} outcome_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [1:0] command = CMD_OBSERVE;
	logic signed [SAMPLE_BITS-1:0] elem0 = 0, elem1 = 0, elem2 = 0, elem3 = 0;
	logic [CL_BITS-1:0] target_cluster = 0;
	logic [SEL_BITS-1:0] selector_index = 0;
	logic [CL_BITS-1:0] chosen_cluster;
	logic [DIST_BITS-1:0] min_distance;
	logic signed [SCAT_BITS-1:0] read_value;
	logic [1:0] status;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [PADDR_BITS-1:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;

	nearest_centroid_assign_accumulate i_dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Predictor state.
	logic [4:0] m_clusters;
	logic [2:0] m_dims;
	logic [15:0] m_weight [DIMS];
	logic signed [15:0] m_seed [CLUSTER_SLOTS][DIMS];
	logic [15:0] m_count [CLUSTER_SLOTS];
	logic [31:0] m_sum [CLUSTER_SLOTS][DIMS];
	logic [47:0] m_scat [CLUSTER_SLOTS][TRI];
	logic [15:0] m_total;

	outcome_t expected_q[$];
	int errors = 0, n_words = 0, n_obs = 0, n_sat = 0, n_range = 0;
	int burst = 0;

	function automatic int eff_clusters();
		return m_clusters == 0 ? 1 :
			(m_clusters > CLUSTER_SLOTS ? CLUSTER_SLOTS : int'(m_clusters));
	endfunction

	function automatic int eff_dims();
		return m_dims == 0 ? 1 : (m_dims > DIMS ? DIMS : int'(m_dims));
	endfunction

	function automatic logic [63:0] weighted_dist(int c, logic signed [15:0] v [DIMS], int nd);
		logic [63:0] acc, sq, w, term;
		longint diff;
		acc = 0;
		for (int d = 0; d < nd; d++) begin
			diff = longint'(m_seed[c][d]) - longint'(v[d]);
			if (diff < 0) diff = -diff;
			sq = diff * diff;
			w = 64'(m_weight[d]);
			term = (w != 0 && sq > DMAX / w) ? DMAX : sq * w;
			acc = (term > DMAX - acc) ? DMAX : acc + term;
		end
		return acc;
	endfunction

	function automatic void predict_word(cmd_t cmd, logic signed [15:0] v [DIMS],
			logic [3:0] tgt, logic [3:0] sel);
		outcome_t o;
		int nd, nc, best, k;
		logic [63:0] bd, dd;
		longint prod;
		o = '{cl: 0, mdist: 0, rv: 0, st: STAT_OK};
		case (cmd)
			CMD_OBSERVE: begin
				nd = eff_dims();
				nc = eff_clusters();
				best = 0;
				bd = weighted_dist(0, v, nd);
				for (int c = 1; c < nc; c++) begin
					dd = weighted_dist(c, v, nd);
					if (dd < bd || (dd == bd && m_count[c] < m_count[best])) begin
						bd = dd;
						best = c;
					end
				end
				if (m_total != CMAX) m_total++;
				o.cl = CL_BITS'(best);
				o.mdist = bd[DIST_BITS-1:0];
				if (m_count[best] == CMAX) begin
					o.st = STAT_SAT;
				end else begin
					m_count[best]++;
					for (int d = 0; d < nd; d++) m_sum[best][d] += 32'(longint'(v[d]));
					k = 0;
					for (int r = 0; r < DIMS; r++)
						for (int d = 0; d <= r; d++) begin
							prod = longint'(v[r]) * longint'(v[d]);
							if (r < nd) m_scat[best][k] += 48'(prod);
							k++;
						end
				end
			end
			CMD_LOAD: begin
				if (sel >= DIMS) o.st = STAT_RANGE;
				else m_seed[tgt][sel] = v[0];
			end
			CMD_CLEAR: begin
				for (int c = 0; c < eff_clusters(); c++) begin
					m_count[c] = 0;
					for (int d = 0; d < DIMS; d++) m_sum[c][d] = 0;
					for (int t = 0; t < TRI; t++) m_scat[c][t] = 0;
				end
				m_total = 0;
			end
			default: begin
				if (sel == 0) o.rv = 48'(m_count[tgt]);
				else if (sel <= DIMS) o.rv = 48'(signed'(m_sum[tgt][sel-1]));
				else if (sel < 5 + TRI) o.rv = m_scat[tgt][sel-5];
				else o.st = STAT_RANGE;
			end
		endcase
		expected_q.push_back(o);
	endfunction

	task automatic send_word(cmd_t cmd, logic signed [15:0] e0, logic signed [15:0] e1,
			logic signed [15:0] e2, logic signed [15:0] e3, logic [3:0] tgt, logic [3:0] sel);
		logic signed [15:0] v [DIMS];
		int gap;
		if (burst == 0) begin
			burst = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 1 : 0;
		end
		burst--;
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		v[0] = e0; v[1] = e1; v[2] = e2; v[3] = e3;
		in_valid <= 1;
		command <= cmd;
		elem0 <= e0; elem1 <= e1; elem2 <= e2; elem3 <= e3;
		target_cluster <= tgt;
		selector_index <= sel;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_word(cmd, v, tgt, sel);
		n_words++;
		if (cmd == CMD_OBSERVE) n_obs++;
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= PADDR_BITS'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
		case (idx)
			REG_ACTIVE_CLUSTERS: m_clusters = val[4:0];
			REG_ACTIVE_DIMS: m_dims = val[2:0];
			default: m_weight[idx - REG_WEIGHT_DIM0] = val[15:0];
		endcase
	endtask

	task automatic configure(logic [4:0] nc, logic [2:0] nd, logic [15:0] w0,
			logic [15:0] w1, logic [15:0] w2, logic [15:0] w3);
		drain();
		write_reg(REG_ACTIVE_CLUSTERS, 32'(nc));
		write_reg(REG_ACTIVE_DIMS, 32'(nd));
		write_reg(REG_WEIGHT_DIM0, 32'(w0));
		write_reg(REG_WEIGHT_DIM1, 32'(w1));
		write_reg(REG_WEIGHT_DIM2, 32'(w2));
		write_reg(REG_WEIGHT_DIM3, 32'(w3));
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic load_seeds(int nc);
		for (int c = 0; c < nc; c++)
			for (int d = 0; d < DIMS; d++)
				send_word(CMD_LOAD, rand_sample(), 16'($urandom), 0, 0, CL_BITS'(c),
					SEL_BITS'(d));
	endtask

	task automatic random_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 78)
			send_word(CMD_OBSERVE, rand_sample(), rand_sample(), rand_sample(), rand_sample(),
				4'($urandom), 4'($urandom));
		else if (r < 88)
			send_word(CMD_LOAD, rand_sample(), 16'($urandom), 16'($urandom), 16'($urandom),
				4'($urandom), 4'($urandom_range(0, 15)));
		else if (r < 90)
			send_word(CMD_CLEAR, 16'($urandom), 0, 0, 0, 4'($urandom), 4'($urandom));
		else
			send_word(CMD_READ, 16'($urandom), 0, 0, 0, 4'($urandom),
				4'($urandom_range(0, 15)));
	endtask

	task automatic test_directed();
		send_word(CMD_OBSERVE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, 0);
		send_word(CMD_LOAD, 16'h8000, 0, 0, 0, 4'd15, 4'd3);
		send_word(CMD_LOAD, 16'h7FFF, 0, 0, 0, 4'd0, 4'd0);
		send_word(CMD_LOAD, 16'h1234, 0, 0, 0, 4'd3, 4'd4);
		send_word(CMD_LOAD, 16'h1234, 0, 0, 0, 4'd3, 4'd15);
		send_word(CMD_OBSERVE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0);
		for (int s = 0; s < 16; s++) send_word(CMD_READ, 0, 0, 0, 0, 4'd0, SEL_BITS'(s));
		send_word(CMD_READ, 0, 0, 0, 0, 4'd15, 4'd0);
		send_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		send_word(CMD_READ, 0, 0, 0, 0, 4'd0, 4'd0);
	endtask

	task automatic test_ties();
		configure(5'd4, 3'd2, 16'd256, 16'd256, 16'd0, 16'd0);
		for (int c = 0; c < 4; c++)
			for (int d = 0; d < DIMS; d++)
				send_word(CMD_LOAD, 16'd10, 0, 0, 0, CL_BITS'(c), SEL_BITS'(d));
		repeat (12) send_word(CMD_OBSERVE, 16'd10, 16'd10, 16'($urandom), 16'($urandom), 0, 0);
		for (int c = 0; c < 4; c++) send_word(CMD_READ, 0, 0, 0, 0, CL_BITS'(c), 4'd0);
	endtask

	task automatic test_single_cluster();
		configure(5'd1, 3'd1, 16'd0, 16'd256, 16'd256, 16'd256);
		send_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 200; i++) begin
			send_word(CMD_OBSERVE, 16'(i * 331), 16'($urandom), 0, 0, 0, 0);
			if (i == 100) drain();
		end
		for (int s = 0; s < 16; s++) send_word(CMD_READ, 0, 0, 0, 0, 4'd0, SEL_BITS'(s));
		send_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_random(int n, logic [4:0] nc, logic [2:0] nd);
		configure(nc, nd, 16'($urandom), 16'($urandom_range(0, 1024)), 16'hFFFF,
			16'($urandom_range(0, 3)));
		load_seeds(nc == 0 ? 1 : (nc > 16 ? 16 : int'(nc)));
		for (int i = 0; i < n; i++) begin
			random_word();
			if (i == n / 2) drain();
		end
	endtask

	always @(posedge clk) begin
		if ($urandom_range(0, 255) < 128) out_stall <= ($urandom_range(0, 3) == 0);
		else if ($urandom_range(0, 9) == 0) out_stall <= 0;
	end

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (e.st == STAT_SAT) n_sat++;
				if (e.st == STAT_RANGE) n_range++;
				if (chosen_cluster !== e.cl) begin
					$error("chosen_cluster exp %0d got %0d", e.cl, chosen_cluster);
					errors++;
				end
				if (min_distance !== e.mdist) begin
					$error("min_distance exp %0h got %0h", e.mdist, min_distance);
					errors++;
				end
				if (read_value !== e.rv) begin
					$error("read_value exp %0h got %0h", e.rv, read_value);
					errors++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					errors++;
				end
			end
		end
	end

	initial begin
		m_clusters = 1;
		m_dims = 4;
		m_total = 0;
		for (int d = 0; d < DIMS; d++) m_weight[d] = 256;
		for (int c = 0; c < CLUSTER_SLOTS; c++) begin
			m_count[c] = 0;
			for (int d = 0; d < DIMS; d++) begin
				m_seed[c][d] = 0;
				m_sum[c][d] = 0;
			end
			for (int t = 0; t < TRI; t++) m_scat[c][t] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_ties();
		test_random(300, 5'd16, 3'd4);
		test_random(250, 5'd31, 3'd7);
		test_random(200, 5'd0, 3'd0);
		test_random(180, 5'd7, 3'd3);
		test_random(180, 5'd1, 3'd4);
		test_single_cluster();
		drain();
		$display("Covered %0d words, %0d observations, %0d saturated and %0d out-of-range.",
			n_words, n_obs, n_sat, n_range);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

	initial begin
		#200ms;
		$display("tb: failure");
		$finish;
	end
endmodule
